FILE: hdl/sjf_pkg.sv
// Shared types and codes for the shortest-job-first ready queue.
package sjf_pkg;

   localparam logic KIND_INSERT   = 1'b0;
   localparam logic KIND_DISPATCH = 1'b1;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [15:0] id;
      logic [15:0] burst;
      logic [31:0] arrival;
   } entry_type;

   typedef struct packed {
      logic        kind;
      logic [15:0] burst_time;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] process_id;
      logic [15:0] run_burst;
      logic [31:0] waiting_time;
      logic [31:0] clock_after;
      logic [31:0] total_waiting;
      logic [15:0] executed_count;
   } rsp_type;

endpackage

FILE: hdl/sjf_req_if.sv
// Request channel: valid/ready with insert or dispatch payload.
interface sjf_req_if;
   import sjf_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: hdl/sjf_rsp_if.sv
// Response channel: valid/ready with the result of one request.
interface sjf_rsp_if;
   import sjf_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: hdl/sjf_ready_queue_dispatcher_unit.sv
// Shortest-job-first ready queue: sorted circular buffer in one synchronous memory.
//
//  channel   dir  handshake              payload
//  req_chan  in   valid/ready            kind, burst_time
//  rsp_chan  out  valid/ready            status, process_id, run_burst, waiting_time,
//                                        clock_after, total_waiting, executed_count
//
// Dispatch: read head, evaluate, finish.
// Insert: the walk steps back from the tail past each queued entry with burst >=
// the new one, then writes the new entry into the hole; each step is one read and one
// write-back of the single-port-read queue memory.
// Full/empty requests go straight to the finish step. One request in flight at a time;
// the finish step waits while the previous result is not yet taken.
// Reset (synchronous) empties the queue; memory contents need no clearing.
module sjf_ready_queue_dispatcher_unit #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic clock,
   input  logic reset,
   sjf_req_if.sink   req_chan,
   sjf_rsp_if.source rsp_chan
);
   import sjf_pkg::*;

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] FULL_OCC  = CW'(QUEUE_DEPTH);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_READ = 4'b0010,
      S_EVAL = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   entry_type queue_mem [QUEUE_DEPTH];
   entry_type rd_data_ff;

   state_type     state_ff, state_in;
   logic          kind_ff, kind_in;
   logic [15:0]   burst_ff, burst_in;
   logic [1:0]    status_ff, status_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [CW-1:0] left_ff, left_in;
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] occ_ff, occ_in;
   logic [15:0]   next_id_ff, next_id_in;
   logic [31:0]   clock_ff, clock_in;
   logic [31:0]   wait_sum_ff, wait_sum_in;
   logic [15:0]   done_ff, done_in;
   logic [15:0]   pid_ff, pid_in;
   logic [15:0]   rburst_ff, rburst_in;
   logic [31:0]   wait_ff, wait_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   entry_type     mem_wdata;
   logic [AW-1:0] mem_raddr;
   logic [AW-1:0] prev_pos;
   logic [CW:0]   tail_sum;
   logic [AW-1:0] tail_slot;
   logic [AW-1:0] head_next;
   logic          out_free;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         queue_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= queue_mem[mem_raddr];
   end

   assign prev_pos  = (pos_ff == '0) ? LAST_SLOT : pos_ff - AW'(1);
   assign head_next = (head_ff == LAST_SLOT) ? '0 : head_ff + AW'(1);
   assign tail_sum  = (CW+1)'(head_ff) + (CW+1)'(occ_ff);
   assign tail_slot = (tail_sum >= (CW+1)'(QUEUE_DEPTH)) ?
                      AW'(tail_sum - (CW+1)'(QUEUE_DEPTH)) : AW'(tail_sum);
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;

   assign req_chan.ready   = (state_ff == S_IDLE);
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      burst_in     = burst_ff;
      status_in    = status_ff;
      pos_in       = pos_ff;
      left_in      = left_ff;
      head_in      = head_ff;
      occ_in       = occ_ff;
      next_id_in   = next_id_ff;
      clock_in     = clock_ff;
      wait_sum_in  = wait_sum_ff;
      done_in      = done_ff;
      pid_in       = pid_ff;
      rburst_in    = rburst_ff;
      wait_in      = wait_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_waddr    = pos_ff;
      mem_wdata    = rd_data_ff;
      mem_raddr    = (kind_ff == KIND_DISPATCH) ? head_ff : prev_pos;

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               kind_in   = req_chan.payload.kind;
               burst_in  = req_chan.payload.burst_time;
               status_in = STATUS_DONE;
               pid_in    = '0;
               rburst_in = '0;
               wait_in   = '0;
               pos_in    = tail_slot;
               left_in   = occ_ff;
               state_in  = S_READ;
               if (req_chan.payload.kind == KIND_INSERT && occ_ff == FULL_OCC) begin
                  status_in = STATUS_FULL;
                  state_in  = S_DONE;
               end else if (req_chan.payload.kind == KIND_DISPATCH && occ_ff == '0) begin
                  status_in = STATUS_EMPTY;
                  state_in  = S_DONE;
               end
            end
         end
         S_READ: begin
            // insert with nothing left to pass: drop the new entry into the hole
            if (kind_ff == KIND_INSERT && left_ff == '0) begin
               mem_we    = 1'b1;
               mem_wdata = '{id: next_id_ff, burst: burst_ff, arrival: clock_ff};
               state_in  = S_DONE;
            end else begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (kind_ff == KIND_DISPATCH) begin
               pid_in    = rd_data_ff.id;
               rburst_in = rd_data_ff.burst;
               wait_in   = clock_ff - rd_data_ff.arrival;
               head_in   = head_next;
               state_in  = S_DONE;
            end else if (burst_ff > rd_data_ff.burst) begin
               mem_we    = 1'b1;
               mem_wdata = '{id: next_id_ff, burst: burst_ff, arrival: clock_ff};
               state_in  = S_DONE;
            end else begin
               // equal or longer burst moves back one slot
               mem_we   = 1'b1;
               pos_in   = prev_pos;
               left_in  = left_ff - CW'(1);
               state_in = S_READ;
            end
         end
         S_DONE: begin
            if (out_free) begin
               if (status_ff == STATUS_DONE && kind_ff == KIND_INSERT) begin
                  pid_in     = next_id_ff;
                  occ_in     = occ_ff + CW'(1);
                  next_id_in = next_id_ff + 16'd1;
               end else if (status_ff == STATUS_DONE) begin
                  occ_in      = occ_ff - CW'(1);
                  wait_sum_in = wait_sum_ff + wait_ff;
                  clock_in    = clock_ff + 32'(rburst_ff);
                  done_in     = done_ff + 16'd1;
               end
               rsp_in = '{status: status_ff, process_id: pid_in, run_burst: rburst_ff,
                          waiting_time: wait_ff, clock_after: clock_in,
                          total_waiting: wait_sum_in, executed_count: done_in};
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         occ_ff       <= '0;
         next_id_ff   <= 16'd1;
         clock_ff     <= '0;
         wait_sum_ff  <= '0;
         done_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         occ_ff       <= occ_in;
         next_id_ff   <= next_id_in;
         clock_ff     <= clock_in;
         wait_sum_ff  <= wait_sum_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      burst_ff  <= burst_in;
      status_ff <= status_in;
      pos_ff    <= pos_in;
      left_ff   <= left_in;
      pid_ff    <= pid_in;
      rburst_ff <= rburst_in;
      wait_ff   <= wait_in;
      rsp_ff    <= rsp_in;
   end

`ifndef ASSERT_OFF
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= FULL_OCC)
      else $error("queue occupancy above depth");

   a_insert_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ && kind_ff == KIND_INSERT && status_ff == STATUS_DONE)
      |-> left_ff < FULL_OCC && left_ff <= occ_ff)
      else $error("insert walk passes more entries than queued");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == STATUS_FULL) |-> occ_ff == FULL_OCC)
      else $error("full reported with room in queue");

   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_chan.ready)
      else $error("request taken while busy");
`endif

endmodule

FILE: bench/sjf_tb_ifs.sv
// Testbench-side note: interfaces come from the RTL; this file holds the scoreboard class.
`timescale 1ns / 1ps
package sjf_tb_pkg;
   import sjf_pkg::*;

   class sjf_scoreboard;
      // predicted queue contents, sorted by burst, index 0 is the head
      entry_type   slots[$];
      logic [15:0] next_pid;
      logic [31:0] sim_clock;
      logic [31:0] wait_total;
      logic [15:0] run_count;
      rsp_type     pending[$];
      int          mismatch_count;
      int          depth;

      function new(int qdepth);
         depth = qdepth;
         next_pid = 16'd1;
         sim_clock = '0;
         wait_total = '0;
         run_count = '0;
         mismatch_count = 0;
      endfunction

      function void note_request(req_type req);
         rsp_type   r;
         entry_type e;
         int        pos;
         r = '0;
         if (req.kind == KIND_INSERT) begin
            if (slots.size() >= depth) begin
               r.status = STATUS_FULL;
            end else begin
               pos = 0;
               while (pos < slots.size() && req.burst_time > slots[pos].burst) pos++;
               e.id = next_pid;
               e.burst = req.burst_time;
               e.arrival = sim_clock;
               slots.insert(pos, e);
               r.status = STATUS_DONE;
               r.process_id = next_pid;
               next_pid = next_pid + 16'd1;
            end
         end else begin
            if (slots.size() == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               e = slots.pop_front();
               r.status = STATUS_DONE;
               r.process_id = e.id;
               r.run_burst = e.burst;
               r.waiting_time = sim_clock - e.arrival;
               wait_total = wait_total + r.waiting_time;
               sim_clock = sim_clock + 32'(e.burst);
               run_count = run_count + 16'd1;
            end
         end
         r.clock_after = sim_clock;
         r.total_waiting = wait_total;
         r.executed_count = run_count;
         pending.push_back(r);
      endfunction

      function void check_result(rsp_type got, time t);
         rsp_type exp;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", t, got);
            mismatch_count++;
            return;
         end
         exp = pending.pop_front();
         if (got.status !== exp.status)
            $display("%0t: status expected %0d actual %0d", t, exp.status, got.status);
         if (got.process_id !== exp.process_id)
            $display("%0t: process_id expected %0d actual %0d", t, exp.process_id,
                     got.process_id);
         if (got.run_burst !== exp.run_burst)
            $display("%0t: run_burst expected %0d actual %0d", t, exp.run_burst,
                     got.run_burst);
         if (got.waiting_time !== exp.waiting_time)
            $display("%0t: waiting_time expected %0d actual %0d", t, exp.waiting_time,
                     got.waiting_time);
         if (got.clock_after !== exp.clock_after)
            $display("%0t: clock_after expected %0d actual %0d", t, exp.clock_after,
                     got.clock_after);
         if (got.total_waiting !== exp.total_waiting)
            $display("%0t: total_waiting expected %0d actual %0d", t, exp.total_waiting,
                     got.total_waiting);
         if (got.executed_count !== exp.executed_count)
            $display("%0t: executed_count expected %0d actual %0d", t,
                     exp.executed_count, got.executed_count);
         if (got !== exp) mismatch_count++;
      endfunction
   endclass
endpackage

FILE: bench/sjf_ready_queue_dispatcher_unit_tb.sv
// Top-level testbench for the shortest-job-first ready queue.
`timescale 1ns / 1ps
module sjf_ready_queue_dispatcher_unit_tb;
   import sjf_pkg::*;
   import sjf_tb_pkg::*;

   localparam int DEPTH = 16;

   logic clock = 1'b0;
   logic reset = 1'b1;
   sjf_req_if req_chan ();
   sjf_rsp_if rsp_chan ();

   sjf_ready_queue_dispatcher_unit #(.QUEUE_DEPTH(DEPTH)) dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan)
   );

   sjf_scoreboard sched_model = new(DEPTH);
   bit  calm_tail = 1'b0;
   bit  long_hold = 1'b0;

   always #10 clock = ~clock;

   initial begin
      req_chan.valid = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready = 1'b0;
   end

   // record transfers on both channels
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready) sched_model.note_request(req_chan.payload);
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         sched_model.check_result(rsp_chan.payload, $time);
   end

   // receiver: random stall bursts, one long hold-off
   initial begin : sink_proc
      int n;
      @(negedge reset);
      forever begin
         if (long_hold) begin
            rsp_chan.ready <= 1'b0;
            repeat (400) @(posedge clock);
            long_hold = 1'b0;
         end else if (!calm_tail && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 14);
            rsp_chan.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // valid stays up after a transfer until the next gap or drain drops it
   task automatic send_item(logic k, logic [15:0] b);
      req_type r;
      r.kind = k;
      r.burst_time = b;
      if (!calm_tail && $urandom_range(0, 4) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.payload <= r;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (sched_model.pending.size() != 0);
   endtask

   function automatic logic [15:0] pick_burst();
      case ($urandom_range(0, 5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(0, 7));
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin : stim_proc
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: empty dispatch, extremes, equal bursts, fill past full, drain
      send_item(KIND_DISPATCH, 16'h0000);
      send_item(KIND_INSERT, 16'hFFFF);
      send_item(KIND_INSERT, 16'h0000);
      send_item(KIND_INSERT, 16'h0005);
      send_item(KIND_INSERT, 16'h0005);
      send_item(KIND_DISPATCH, 16'hFFFF);
      for (int i = 0; i < 15; i++) send_item(KIND_INSERT, 16'($urandom_range(0, 3)));
      send_item(KIND_INSERT, 16'h1234);
      for (int i = 0; i < 3; i++) send_item(KIND_DISPATCH, 16'($urandom));
      // long receiver hold-off while requests keep coming
      long_hold = 1'b1;
      for (int i = 0; i < 8; i++) send_item(KIND_INSERT, pick_burst());
      wait_drained();
      for (int i = 0; i < 20; i++) send_item(KIND_DISPATCH, 16'($urandom));
      wait_drained();
      // random: runs of balanced traffic alternating with runs biased toward full or empty
      for (int i = 0; i < 600; i++) begin
         int bias;
         if (i > 520) calm_tail = 1'b1;
         bias = (i / 60) % 3;
         if ($urandom_range(0, 9) < (bias == 0 ? 5 : (bias == 1 ? 7 : 3)))
            send_item(KIND_INSERT, pick_burst());
         else
            send_item(KIND_DISPATCH, 16'($urandom));
      end
      wait_drained();
      repeat (20) @(posedge clock);
      if (sched_model.mismatch_count == 0 && sched_model.pending.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin : watchdog
      #20ms;
      $display("Mismatches found");
      $finish;
   end
endmodule
